[rtl/assert_macros.svh]
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/mcst_pkg.sv]
// Shared constants, codes and types of the timer table.
`timescale 1ns / 1ps
`default_nettype none

package mcst_pkg;

    // Table size and result limit
    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Field widths
    localparam int REQ_W     = 2;
    localparam int TICK_W    = 32;
    localparam int SEL_W     = 3;
    localparam int KIND_W    = 3;
    localparam int SLOT_ID_W = 3;
    localparam int ARMED_W   = 4;
    localparam int CMP_W     = (SEL_W > CNT_W) ? SEL_W : CNT_W;

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd2;

    // Result kinds on the output channel
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOPPED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE_DUE = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_STOP,
        OP_RUN
    } t_op;

    // Classified command as queued for the back end
    typedef struct packed {
        t_op                op;
        logic [TICK_W-1:0]  now;
        logic [TICK_W-1:0]  interval;
        logic [TICK_W-1:0]  due;
        logic               periodic;
        logic [SEL_W-1:0]   sel;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [ARMED_W-1:0]   armed_count;
        logic                 last;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/mcst_if.sv]
// Request and result channel interfaces of the timer table.
`timescale 1ns / 1ps
`default_nettype none

interface mcst_req_if import mcst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TICK_W-1:0] now;
    logic [TICK_W-1:0] interval;
    logic              repeat_req;
    logic [SEL_W-1:0]  slot_sel;

    modport source (
        output valid, req_type, now, interval, repeat_req, slot_sel,
        input  ready
    );
    modport sink (
        input  valid, req_type, now, interval, repeat_req, slot_sel,
        output ready
    );
endinterface

interface mcst_rsp_if import mcst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [ARMED_W-1:0]   armed_count;
    logic                 last;

    modport source (
        output valid, kind, slot_id, armed_count, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot_id, armed_count, last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/mcst_front.sv]
// Front end: accept request beats, classify them and precompute the due tick.
`timescale 1ns / 1ps
`default_nettype none

module mcst_front import mcst_pkg::*; (
    mcst_req_if.sink  i_req,
    input  logic      i_full,
    output t_cmd_beat o_push
);

    logic known;
    t_op  op;

    // Take a beat whenever the queue has room
    assign i_req.ready = !i_full;

    // Map request codes to operations; drop unknown codes
    always_comb begin
        known = 1'b1;
        op    = OP_ADD;
        case (i_req.req_type)
            REQ_ADD:  op = OP_ADD;
            REQ_STOP: op = OP_STOP;
            REQ_RUN:  op = OP_RUN;
            default:  known = 1'b0;
        endcase
    end

    // Build the queued command
    always_comb begin
        o_push.valid        = i_req.valid && !i_full && known;
        o_push.cmd.op       = op;
        o_push.cmd.now      = i_req.now;
        o_push.cmd.interval = i_req.interval;
        o_push.cmd.due      = i_req.now + i_req.interval;
        o_push.cmd.periodic = i_req.repeat_req;
        o_push.cmd.sel      = i_req.slot_sel;
    end

endmodule

`default_nettype wire

[rtl/mcst_fifo.sv]
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcst_fifo import mcst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_beat i_push,
    input  logic      i_pop,
    output logic      o_full,
    output t_cmd_beat o_head
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               push;
    logic               pop;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    assign push = i_push.valid && !o_full;
    assign pop  = i_pop && (r_count != '0);

    // Advance pointers with wrap and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the command payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    `ASSERT_CLK(a_q_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

[rtl/mcst_back.sv]
// Back end: slot table, add and stop execution, run scan and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mcst_back import mcst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_beat   i_head,
    output logic        o_pop,
    mcst_rsp_if.source  o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Slot memories: due tick, and periodic flag with period
    logic [TICK_W-1:0] r_due_mem [NUM_SLOTS];
    logic [TICK_W:0]   r_per_mem [NUM_SLOTS];
    logic [TICK_W-1:0] r_due_q;
    logic [TICK_W:0]   r_per_q;

    logic                 r_state, n_state;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [NUM_SLOTS-1:0] r_armed, n_armed;
    logic [CNT_W-1:0]     r_armed_cnt, n_armed_cnt;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [FIRE_W-1:0]    r_fires, n_fires;
    logic [TICK_W-1:0]    r_now, n_now;
    logic                 r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]     r_pend_slot, n_pend_slot;
    logic [CNT_W-1:0]     r_pend_cnt, n_pend_cnt;
    logic                 r_out_vld, n_out_vld;
    t_rsp                 r_out, n_out;

    logic              out_free;
    logic              due_we;
    logic              per_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TICK_W-1:0] due_wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [TICK_W-1:0] diff;
    logic              fire;
    logic              stop_hit;
    logic [IDX_W-1:0]  add_slot;
    logic [IDX_W-1:0]  sel_slot;

    assign out_free = !r_out_vld || o_rsp.ready;
    assign idx      = IDX_W'(r_idx);
    assign add_slot = IDX_W'(r_used);
    assign sel_slot = IDX_W'(i_head.cmd.sel);
    assign in_range = (r_idx < r_used) && (r_fires < FIRE_W'(MAX_RESULTS));
    assign diff     = r_now - r_due_q;
    assign fire     = in_range && r_armed[idx] && !diff[TICK_W-1];
    assign stop_hit = (CMP_W'(i_head.cmd.sel) < CMP_W'(r_used)) && r_armed[sel_slot];

    // Execute commands and walk the slots on a run
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_armed     = r_armed;
        n_armed_cnt = r_armed_cnt;
        n_idx       = r_idx;
        n_fires     = r_fires;
        n_now       = r_now;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_pend_cnt  = r_pend_cnt;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        due_we      = 1'b0;
        per_we      = 1'b0;
        mem_waddr   = idx;
        due_wdata   = r_due_q + r_per_q[TICK_W-1:0];
        rd_en       = 1'b0;
        rd_addr     = IDX_W'(r_idx + CNT_W'(1));

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.op)
                        OP_ADD: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                n_out_vld = 1'b1;
                                n_out.last = 1'b1;
                                if (r_used >= CNT_W'(NUM_SLOTS)) begin
                                    n_out.kind        = KIND_FULL;
                                    n_out.slot_id     = '0;
                                    n_out.armed_count = ARMED_W'(r_armed_cnt);
                                end else begin
                                    due_we             = 1'b1;
                                    per_we             = 1'b1;
                                    mem_waddr          = add_slot;
                                    due_wdata          = i_head.cmd.due;
                                    n_armed[add_slot]  = 1'b1;
                                    n_used             = r_used + CNT_W'(1);
                                    n_armed_cnt        = r_armed_cnt + CNT_W'(1);
                                    n_out.kind         = KIND_ADDED;
                                    n_out.slot_id      = SLOT_ID_W'(r_used);
                                    n_out.armed_count  = ARMED_W'(n_armed_cnt);
                                end
                            end
                        end
                        OP_STOP: begin
                            if (out_free) begin
                                o_pop = 1'b1;
                                if (stop_hit) begin
                                    n_armed[sel_slot] = 1'b0;
                                    n_armed_cnt       = r_armed_cnt - CNT_W'(1);
                                end
                                n_out_vld         = 1'b1;
                                n_out.kind        = KIND_STOPPED;
                                n_out.slot_id     = '0;
                                n_out.armed_count = ARMED_W'(n_armed_cnt);
                                n_out.last        = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            // Prime the read of slot zero
                            o_pop      = 1'b1;
                            n_state    = ST_SCAN;
                            n_idx      = '0;
                            n_fires    = '0;
                            n_now      = i_head.cmd.now;
                            n_pend_vld = 1'b0;
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (in_range) begin
                    if (!fire) begin
                        n_idx = r_idx + CNT_W'(1);
                        rd_en = 1'b1;
                    end else if (!r_pend_vld || out_free) begin
                        // Release the held fire; it is not the last one
                        if (r_pend_vld) begin
                            n_out_vld         = 1'b1;
                            n_out.kind        = KIND_FIRED;
                            n_out.slot_id     = SLOT_ID_W'(r_pend_slot);
                            n_out.armed_count = ARMED_W'(r_pend_cnt);
                            n_out.last        = 1'b0;
                        end
                        if (r_per_q[TICK_W]) begin
                            due_we = 1'b1;
                        end else begin
                            n_armed[idx] = 1'b0;
                            n_armed_cnt  = r_armed_cnt - CNT_W'(1);
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = idx;
                        n_pend_cnt  = n_armed_cnt;
                        n_fires     = r_fires + FIRE_W'(1);
                        n_idx       = r_idx + CNT_W'(1);
                        rd_en       = 1'b1;
                    end
                end else if (out_free) begin
                    // Close the run with the held fire or a nothing-due beat
                    n_out_vld  = 1'b1;
                    n_out.last = 1'b1;
                    if (r_pend_vld) begin
                        n_out.kind        = KIND_FIRED;
                        n_out.slot_id     = SLOT_ID_W'(r_pend_slot);
                        n_out.armed_count = ARMED_W'(r_pend_cnt);
                    end else begin
                        n_out.kind        = KIND_NONE_DUE;
                        n_out.slot_id     = '0;
                        n_out.armed_count = ARMED_W'(r_armed_cnt);
                    end
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_armed     <= '0;
            r_armed_cnt <= '0;
            r_idx       <= '0;
            r_fires     <= '0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_armed     <= n_armed;
            r_armed_cnt <= n_armed_cnt;
            r_idx       <= n_idx;
            r_fires     <= n_fires;
            r_pend_vld  <= n_pend_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_pend_slot <= n_pend_slot;
        r_pend_cnt  <= n_pend_cnt;
        r_out       <= n_out;
    end

    // Slot memories with registered read
    always_ff @(posedge i_clk) begin
        if (due_we) begin
            r_due_mem[mem_waddr] <= due_wdata;
        end
        if (per_we) begin
            r_per_mem[mem_waddr] <= {i_head.cmd.periodic, i_head.cmd.interval};
        end
        if (rd_en) begin
            r_due_q <= r_due_mem[rd_addr];
            r_per_q <= r_per_mem[rd_addr];
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.slot_id     = r_out.slot_id;
    assign o_rsp.armed_count = r_out.armed_count;
    assign o_rsp.last        = r_out.last;

    `ASSERT_CLK(a_cnt_match, i_clk, i_rst_n, r_armed_cnt == CNT_W'($countones(r_armed)), "armed count out of step with flags")
    `ASSERT_CLK(a_cnt_le_used, i_clk, i_rst_n, r_armed_cnt <= r_used, "more armed slots than allocated")
    `ASSERT_NEVER(a_pend_idle, i_clk, i_rst_n, r_pend_vld && (r_state == ST_IDLE), "held fire left outside a run")

endmodule

`default_nettype wire

[rtl/multi_channel_soft_timer.sv]
// Top level of the eight-slot timer table with periodic and one-shot timers.
// Add and stop: the request passes the command queue, then the back end registers the result beat.
// Run: the back end scans the allocated slots in turn, then registers the last beat.
// The back end takes one request at a time; a run holds it in the scan state to the end.
// Result stalls hold the back end; a two-entry queue buffers requests meanwhile.
// Reset (i_rst_n low, synchronous) disarms and frees all slots; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_soft_timer import mcst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcst_req_if.sink   i_req,
    mcst_rsp_if.source o_rsp
);

    t_cmd_beat push;
    t_cmd_beat head;
    logic      q_full;
    logic      pop;

    mcst_front u_front (
        .i_req  (i_req),
        .i_full (q_full),
        .o_push (push)
    );

    mcst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    mcst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

[tb/multi_channel_soft_timer_tb.sv]
// Self-checking testbench of the timer table: add, stop and run beats against a shadow table.
`timescale 1ns / 1ps

module multi_channel_soft_timer_tb;
    import mcst_pkg::*;

    // Request code that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RUN_LIMIT_NS   = 2_000_000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int MAX_PRINTS     = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mcst_req_if req_ch ();
    mcst_rsp_if rsp_ch ();

    multi_channel_soft_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the timer table
    logic [TICK_W-1:0] slot_period   [NUM_SLOTS];
    logic [TICK_W-1:0] slot_due      [NUM_SLOTS];
    logic              slot_periodic [NUM_SLOTS];
    logic              slot_armed    [NUM_SLOTS];
    int unsigned       slots_taken;
    t_rsp              awaited_rsp [$];

    // Flow control and bookkeeping
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    int unsigned       items_sent;
    int unsigned       mismatch_count;
    int unsigned       fired_seen;
    int unsigned       none_seen;
    int unsigned       full_seen;
    int unsigned       added_seen;
    int unsigned       stop_seen;
    logic [TICK_W-1:0] tick_now;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [ARMED_W-1:0] armed_total();
        int unsigned n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_armed[i]) n++;
        end
        return ARMED_W'(n);
    endfunction

    function automatic void await_rsp(logic [KIND_W-1:0] kind, int unsigned slot, logic last);
        t_rsp r;
        r.kind        = kind;
        r.slot_id     = SLOT_ID_W'(slot);
        r.armed_count = armed_total();
        r.last        = last;
        awaited_rsp   = {awaited_rsp, r};
    endfunction

    // Apply one request to the shadow table and queue the beats it should produce
    function automatic void predict_timer_results(logic [REQ_W-1:0] req, logic [TICK_W-1:0] now,
            logic [TICK_W-1:0] ivl, logic rep, logic [SEL_W-1:0] sel);
        int unsigned       fired;
        logic [TICK_W-1:0] lag;
        t_rsp              tail;
        fired = 0;
        case (req)
            REQ_ADD: begin
                if (slots_taken >= NUM_SLOTS) begin
                    await_rsp(KIND_FULL, 0, 1'b1);
                end else begin
                    slot_period[slots_taken]   = ivl;
                    slot_periodic[slots_taken] = rep;
                    slot_due[slots_taken]      = now + ivl;
                    slot_armed[slots_taken]    = 1'b1;
                    await_rsp(KIND_ADDED, slots_taken, 1'b1);
                    slots_taken++;
                end
            end
            REQ_STOP: begin
                // slots beyond the allocated ones are left alone
                if (sel < slots_taken) slot_armed[sel] = 1'b0;
                await_rsp(KIND_STOPPED, 0, 1'b1);
            end
            REQ_RUN: begin
                for (int i = 0; i < slots_taken && fired < MAX_RESULTS; i++) begin
                    if (slot_armed[i]) begin
                        // due when the wrapped difference is not negative
                        lag = now - slot_due[i];
                        if (!lag[TICK_W-1]) begin
                            if (slot_periodic[i]) slot_due[i] = slot_due[i] + slot_period[i];
                            else slot_armed[i] = 1'b0;
                            await_rsp(KIND_FIRED, unsigned'(i), 1'b0);
                            fired++;
                        end
                    end
                end
                if (fired == 0) begin
                    await_rsp(KIND_NONE_DUE, 0, 1'b1);
                end else begin
                    tail = awaited_rsp.pop_back();
                    tail.last = 1'b1;
                    awaited_rsp = {awaited_rsp, tail};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // Send one request beat; called and returns at a falling edge
    task automatic send_req(logic [REQ_W-1:0] req, logic [TICK_W-1:0] now,
            logic [TICK_W-1:0] ivl, logic rep, logic [SEL_W-1:0] sel);
        // hold off the beat at random
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.req_type   = req;
        req_ch.now        = now;
        req_ch.interval   = ivl;
        req_ch.repeat_req = rep;
        req_ch.slot_sel   = sel;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_timer_results(req, now, ivl, rep, sel);
        if (req != REQ_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    // Stall the result channel at random
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    // Compare each result beat with the oldest awaited one
    always @(posedge i_clk) begin : rsp_check
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.kind        = rsp_ch.kind;
            got.slot_id     = rsp_ch.slot_id;
            got.armed_count = rsp_ch.armed_count;
            got.last        = rsp_ch.last;
            if (awaited_rsp.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d slot %0d",
                    got.kind, got.slot_id));
            end else begin
                want = awaited_rsp.pop_front();
                check_field("kind", 8'(got.kind), 8'(want.kind));
                check_field("slot_id", 8'(got.slot_id), 8'(want.slot_id));
                check_field("armed_count", 8'(got.armed_count), 8'(want.armed_count));
                check_field("last", 8'(got.last), 8'(want.last));
                case (want.kind)
                    KIND_ADDED:    added_seen++;
                    KIND_FULL:     full_seen++;
                    KIND_STOPPED:  stop_seen++;
                    KIND_FIRED:    fired_seen++;
                    KIND_NONE_DUE: none_seen++;
                    default: ;
                endcase
            end
        end
    end

    // Requests on an empty table
    task automatic test_empty_table();
        send_req(REQ_RUN, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_STOP, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7);
    endtask

    // Fill the table with extreme intervals and ticks, then overflow it
    task automatic test_add_extremes();
        // one-shot with zero interval: due at once
        send_req(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd7);
        // periodic with zero interval: due time never moves
        send_req(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 3'd0);
        // slot beyond the allocated ones
        send_req(REQ_STOP, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd7);
        send_req(REQ_RUN, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_ADD, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 3'd0);
        send_req(REQ_ADD, 32'h0000_0000, 32'h8000_0000, 1'b0, 3'd0);
        send_req(REQ_ADD, 32'h0000_0000, 32'h0000_0007, 1'b1, 3'd0);
        send_req(REQ_ADD, 32'h0000_0002, 32'h0000_0003, 1'b1, 3'd0);
        send_req(REQ_ADD, 32'h0000_0000, 32'h0001_0000, 1'b1, 3'd0);
        send_req(REQ_ADD, 32'h1234_5678, 32'h5A5A_A5A5, 1'b0, 3'd0);
        // no free slot left
        send_req(REQ_ADD, 32'h0000_0010, 32'h0000_0001, 1'b1, 3'd0);
    endtask

    // Runs around the sign boundary of the tick, and stops of armed and idle slots
    task automatic test_stop_and_wrap();
        send_req(REQ_RUN, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_RUN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_STOP, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd6);
        // same slot again, now disarmed
        send_req(REQ_STOP, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd6);
        send_req(REQ_RUN, 32'h8000_0000, 32'h0000_0000, 1'b0, 3'd0);
        send_req(REQ_RUN, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0);
    endtask

    // Mostly runs on a creeping tick, with adds, stops and ignored codes mixed in
    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_of,
            int unsigned n_items);
        int unsigned      start;
        int unsigned      pick;
        logic [REQ_W-1:0] req;
        send_idle_pct = idle_pct;
        stall_pct     = stall_of;
        start         = items_sent;
        while (items_sent - start < n_items) begin
            // advance the tick: small steps, now and then a jump anywhere
            if ($urandom_range(9) == 0) tick_now = $urandom();
            else tick_now = tick_now + $urandom_range(3);
            pick = $urandom_range(99);
            if (pick < 86) req = REQ_RUN;
            else if (pick < 94) req = REQ_ADD;
            else if (pick < 97) req = REQ_STOP;
            else req = REQ_UNUSED;
            send_req(req, tick_now, $urandom(), 1'($urandom_range(1)),
                SEL_W'($urandom_range(NUM_SLOTS - 1)));
        end
    endtask

    // Let every awaited beat arrive, then watch for strays
    task automatic wait_drain();
        req_ch.valid = 1'b0;
        while (awaited_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ADD;
        req_ch.now        = '0;
        req_ch.interval   = '0;
        req_ch.repeat_req = 1'b0;
        req_ch.slot_sel   = '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        items_sent        = 0;
        mismatch_count    = 0;
        fired_seen        = 0;
        none_seen         = 0;
        full_seen         = 0;
        added_seen        = 0;
        stop_seen         = 0;
        slots_taken       = 0;
        tick_now          = '0;
        for (int i = 0; i < NUM_SLOTS; i++) slot_armed[i] = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_add_extremes();
        test_stop_and_wrap();
        test_random_traffic(0, 0, 105);
        test_random_traffic(84, 0, 105);
        test_random_traffic(0, 84, 105);
        test_random_traffic(35, 35, 105);
        wait_drain();

        $display("Covered %0d requests under four flow-control patterns.", items_sent);
        $display("Beats: %0d added, %0d full, %0d stop, %0d fired, %0d none due; %0d mismatches.",
            added_seen, full_seen, stop_seen, fired_seen, none_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mcst_pkg.sv
rtl/mcst_if.sv
rtl/mcst_front.sv
rtl/mcst_fifo.sv
rtl/mcst_back.sv
rtl/multi_channel_soft_timer.sv
tb/multi_channel_soft_timer_tb.sv
